// ===== rtl/sblm_pkg.sv =====
// ----------------------------------------------------------------------------
// sblm_pkg
// Shared types and constants for the spectrum band level meter.
// ----------------------------------------------------------------------------
package sblm_pkg;

  // request codes
  localparam logic [1:0] REQ_UPDATE = 2'd0;
  localparam logic [1:0] REQ_FRAME  = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_FFT_SIZE      = 2'd0;
  localparam logic [1:0] CFG_SAMPLE_RATE   = 2'd1;
  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd2;

  // reset values of the configuration registers
  localparam logic [16:0] FFT_SIZE_RST      = 17'd1024;
  localparam logic [17:0] SAMPLE_RATE_RST   = 18'd44100;
  localparam logic [1:0]  CHANNEL_COUNT_RST = 2'd2;

  localparam logic signed [15:0] DB_FLOOR = -16'sd110;
  localparam logic signed [7:0]  DB_NONE  = -8'sd100;
  localparam logic [15:0]        BIN_MAX  = 16'hffff;

  // one table entry as stored in the entry memory
  typedef struct packed {
    logic [15:0]       bin;
    logic [23:0]       power;
    logic signed [7:0] db;
  } entry_t;

endpackage

// ===== rtl/spectrum_band_level_meter.sv =====
// ----------------------------------------------------------------------------
// spectrum_band_level_meter
// Table of spectrum entries with band queries giving rms level and mean dB.
// ----------------------------------------------------------------------------
// update and frame-done items give no result
// a band query runs two 33-step bin divisions, a scan of the entry memory at one
//   entry per cycle, a 32-step power division, a 12-step square root and a 15-step
//   dB division, all on one shared subtract unit; the root and power division are
//   skipped with no nonzero power, the dB division with no nonzero dB, and a result
//   still held on the output stalls the query
// the block takes one item at a time; in_ready is low while a query runs and is
//   back in the same cycle the result transfer is offered
// synchronous reset clears the valid bits and frame counter and restores the
//   register defaults
module spectrum_band_level_meter import sblm_pkg::*; #(
  parameter int ENTRIES = 32
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [17:0]        cfg_data,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [4:0]         entry_index,
  input  logic               channel,
  input  logic [15:0]        bin,
  input  logic [23:0]        power,
  input  logic signed [15:0] db_value,
  input  logic [15:0]        lo_freq,
  input  logic [15:0]        hi_freq,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        level,
  output logic signed [7:0]  mean_db,
  output logic [31:0]        frame_count
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_BLO_SETUP  = 4'd1;
  localparam logic [3:0] ST_BLO        = 4'd2;
  localparam logic [3:0] ST_BHI_SETUP  = 4'd3;
  localparam logic [3:0] ST_BHI        = 4'd4;
  localparam logic [3:0] ST_SCAN_SETUP = 4'd5;
  localparam logic [3:0] ST_SCAN       = 4'd6;
  localparam logic [3:0] ST_PDIV_SETUP = 4'd7;
  localparam logic [3:0] ST_PDIV       = 4'd8;
  localparam logic [3:0] ST_SQRT_SETUP = 4'd9;
  localparam logic [3:0] ST_SQRT       = 4'd10;
  localparam logic [3:0] ST_DDIV_SETUP = 4'd11;
  localparam logic [3:0] ST_DDIV       = 4'd12;
  localparam logic [3:0] ST_DONE       = 4'd13;

  logic [3:0]  state;

  logic [16:0] fft_size;
  logic [17:0] sample_rate;
  logic [1:0]  channel_count;
  logic [31:0] frames_done;

  logic [15:0] freq_lo_q;
  logic [15:0] freq_hi_q;
  logic [15:0] bin_lo;
  logic [15:0] bin_hi;

  // entry table
  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;
  entry_t             rd_ent;
  logic               rd_hit;

  // scan accumulators
  logic [CW-1:0]      scan_cnt;
  logic [31:0]        psum;
  logic [CW-1:0]      pcnt;
  logic [14:0]        dmag;
  logic [CW-1:0]      dcnt;

  // shared subtract unit registers
  logic [32:0]        dvd;
  logic [17:0]        dvs;
  logic [19:0]        rem;
  logic [32:0]        quo;
  logic [5:0]         step_cnt;

  logic [11:0]        level_q;
  logic signed [7:0]  mdb_q;

  // request decode
  logic               in_xfer;
  logic [7:0]         idx_ext;
  logic               upd_en;
  logic [AW-1:0]      wr_addr;
  logic signed [7:0]  db_clamped;
  logic [AW-1:0]      rd_addr;
  logic               scan_issue;
  logic               in_band;
  logic [7:0]         db_mag;

  // shared unit datapath
  logic               sqrt_mode;
  logic [19:0]        rem_sh;
  logic [19:0]        sub_b;
  logic [20:0]        diff;
  logic               borrow;
  logic [15:0]        quo_sat;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;

  assign idx_ext = {3'b000, entry_index};
  assign wr_addr = idx_ext[AW-1:0];
  assign upd_en  = in_xfer && (req_type == REQ_UPDATE) && ({1'b0, idx_ext} < 9'(ENTRIES))
                   && !(channel && (channel_count < 2'd2));

  always_comb begin
    if (db_value < DB_FLOOR) begin
      db_clamped = DB_FLOOR[7:0];
    end else if (db_value > 16'sd0) begin
      db_clamped = 8'sd0;
    end else begin
      db_clamped = db_value[7:0];
    end
  end

  assign scan_issue = (state == ST_SCAN) && (scan_cnt != CW'(ENTRIES));
  assign rd_addr    = scan_cnt[AW-1:0];
  assign in_band    = (rd_ent.bin >= bin_lo) && (rd_ent.bin <= bin_hi);
  assign db_mag     = 8'd0 - rd_ent.db;

  // one compare-and-subtract step, for long division or the square root
  assign sqrt_mode = (state == ST_SQRT);
  always_comb begin
    if (sqrt_mode) begin
      rem_sh = {rem[17:0], dvd[32:31]};
      sub_b  = {6'd0, quo[11:0], 2'b01};
    end else begin
      rem_sh = {rem[18:0], dvd[32]};
      sub_b  = {2'b00, dvs};
    end
  end
  assign diff    = {1'b0, rem_sh} - {1'b0, sub_b};
  assign borrow  = diff[20];
  assign quo_sat = (|quo[32:16]) ? BIN_MAX : quo[15:0];

  // entry memory
  always_ff @(posedge clk) begin
    if (upd_en) begin
      mem[wr_addr] <= '{bin: bin, power: power, db: db_clamped};
    end
    rd_ent <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (upd_en) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  // configuration and frame counter
  always_ff @(posedge clk) begin
    if (rst) begin
      fft_size      <= FFT_SIZE_RST;
      sample_rate   <= SAMPLE_RATE_RST;
      channel_count <= CHANNEL_COUNT_RST;
      frames_done   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FFT_SIZE:      fft_size      <= cfg_data[16:0];
          CFG_SAMPLE_RATE:   sample_rate   <= cfg_data;
          CFG_CHANNEL_COUNT: channel_count <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_xfer && (req_type == REQ_FRAME)) begin
        frames_done <= frames_done + 32'd1;
      end
    end
  end

  // query sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      rd_hit    <= 1'b0;
    end else begin
      // the done state reloads the output itself
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer && (req_type == REQ_QUERY)) begin
            freq_lo_q <= lo_freq;
            freq_hi_q <= hi_freq;
            state     <= ST_BLO_SETUP;
          end
        end
        ST_BLO_SETUP: begin
          dvd      <= {17'd0, freq_lo_q} * {16'd0, fft_size};
          dvs      <= sample_rate;
          rem      <= '0;
          quo      <= '0;
          step_cnt <= 6'd33;
          state    <= ST_BLO;
        end
        ST_BHI_SETUP: begin
          bin_lo   <= quo_sat;
          dvd      <= {17'd0, freq_hi_q} * {16'd0, fft_size};
          rem      <= '0;
          quo      <= '0;
          step_cnt <= 6'd33;
          state    <= ST_BHI;
        end
        ST_SCAN_SETUP: begin
          bin_hi   <= quo_sat;
          scan_cnt <= '0;
          psum     <= '0;
          pcnt     <= '0;
          dmag     <= '0;
          dcnt     <= '0;
          rd_hit   <= 1'b0;
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          // read issued this cycle, data and hit flag seen the next
          rd_hit <= scan_issue && entry_valid[rd_addr];
          if (scan_issue) begin
            scan_cnt <= scan_cnt + CW'(1);
          end else begin
            state <= ST_PDIV_SETUP;
          end
          if (rd_hit && in_band) begin
            if (rd_ent.power != 24'd0) begin
              psum <= psum + {8'd0, rd_ent.power};
              pcnt <= pcnt + CW'(1);
            end
            if (rd_ent.db != 8'sd0) begin
              dmag <= dmag + {7'd0, db_mag};
              dcnt <= dcnt + CW'(1);
            end
          end
        end
        ST_PDIV_SETUP: begin
          if (pcnt == '0) begin
            level_q <= '0;
            state   <= ST_DDIV_SETUP;
          end else begin
            dvd      <= {psum, 1'b0};
            dvs      <= 18'(pcnt);
            rem      <= '0;
            quo      <= '0;
            step_cnt <= 6'd32;
            state    <= ST_PDIV;
          end
        end
        ST_SQRT_SETUP: begin
          // mean power sits left-aligned, consumed two bits a step
          dvd      <= {quo[23:0], 9'd0};
          rem      <= '0;
          quo      <= '0;
          step_cnt <= 6'd12;
          state    <= ST_SQRT;
        end
        ST_DDIV_SETUP: begin
          if (dcnt == '0) begin
            mdb_q <= DB_NONE;
            state <= ST_DONE;
          end else begin
            dvd      <= {dmag, 18'd0};
            dvs      <= 18'(dcnt);
            rem      <= '0;
            quo      <= '0;
            step_cnt <= 6'd15;
            state    <= ST_DDIV;
          end
        end
        ST_BLO, ST_BHI, ST_PDIV, ST_SQRT, ST_DDIV: begin
          rem      <= borrow ? rem_sh : diff[19:0];
          quo      <= {quo[31:0], ~borrow};
          dvd      <= sqrt_mode ? {dvd[30:0], 2'b00} : {dvd[31:0], 1'b0};
          step_cnt <= step_cnt - 6'd1;
          if (step_cnt == 6'd1) begin
            case (state)
              ST_BLO:  state <= ST_BHI_SETUP;
              ST_BHI:  state <= ST_SCAN_SETUP;
              ST_PDIV: state <= ST_SQRT_SETUP;
              ST_SQRT: state <= ST_DDIV_SETUP;
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            level       <= level_q;
            mean_db     <= mdb_q;
            frame_count <= frames_done;
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // capture results as each unit pass finishes
      if (state == ST_SQRT && step_cnt == 6'd1) begin
        level_q <= {quo[10:0], ~borrow};
      end
      if (state == ST_DDIV && step_cnt == 6'd1) begin
        mdb_q <= 8'sd0 - $signed({quo[6:0], ~borrow});
      end
    end
  end

endmodule
